// ===== src/assert_macros.svh =====
// Assertion helpers used by the normal engine RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TFN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tfn check failed");

// Next-cycle implication, off during reset.
`define TFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tfn check failed");

`endif

// ===== src/tfn_pkg.sv =====
// Shared types and constants of the face normal engine.
// No dependencies.
package tfn_pkg;

  // normalized magnitude width: top bit lands at bit 30
  localparam int NORM_BITS   = 31;
  localparam int SQRT_STEPS  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_WIDTH   = 16;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } side_t;

  function automatic int edge_shift(input int cw);
    return (cw > 30) ? cw - 30 : 0;
  endfunction

  function automatic int edge_width(input int cw);
    return cw + 1 - edge_shift(cw);
  endfunction

  // width of one signed cross product component
  function automatic int cross_width(input int cw);
    return 2 * edge_width(cw) + 1;
  endfunction

endpackage

// ===== src/tfn_front.sv =====
// Front end: edge subtraction and cross product, two register stages.
// Depends on tfn_pkg; pushes into tfn_queue.
module tfn_front import tfn_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int CW          = cross_width(16)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] p1_x_i,
  input  logic [COORD_WIDTH-1:0] p1_y_i,
  input  logic [COORD_WIDTH-1:0] p1_z_i,
  input  logic [COORD_WIDTH-1:0] p2_x_i,
  input  logic [COORD_WIDTH-1:0] p2_y_i,
  input  logic [COORD_WIDTH-1:0] p2_z_i,
  input  logic [COORD_WIDTH-1:0] p3_x_i,
  input  logic [COORD_WIDTH-1:0] p3_y_i,
  input  logic [COORD_WIDTH-1:0] p3_z_i,
  input  logic                   full_i,
  output logic                   push_o,
  output logic [2:0][CW-1:0]     c_o,
  output logic                   deg_o
);

  localparam int ES = edge_shift(COORD_WIDTH);
  localparam int EW = edge_width(COORD_WIDTH);
  localparam int PW = 2 * EW;

  logic [COORD_WIDTH-1:0] pa [3];
  logic [COORD_WIDTH-1:0] pb [3];
  logic [COORD_WIDTH-1:0] pc [3];
  logic signed [COORD_WIDTH:0] d1 [3];
  logic signed [COORD_WIDTH:0] d2 [3];
  logic signed [EW-1:0] e1_d [3];
  logic signed [EW-1:0] e2_d [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] pr_q [6];
  logic signed [CW-1:0] c [3];
  logic v1_q, v2_q, adv;

  assign pa = '{p1_x_i, p1_y_i, p1_z_i};
  assign pb = '{p2_x_i, p2_y_i, p2_z_i};
  assign pc = '{p3_x_i, p3_y_i, p3_z_i};

  assign adv        = !v2_q || !full_i;
  assign in_ready_o = adv;
  assign push_o     = v2_q && !full_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed({pb[i][COORD_WIDTH-1], pb[i]}) - $signed({pa[i][COORD_WIDTH-1], pa[i]});
      d2[i] = $signed({pa[i][COORD_WIDTH-1], pa[i]}) - $signed({pc[i][COORD_WIDTH-1], pc[i]});
      e1_d[i] = EW'(d1[i] >>> ES);
      e2_d[i] = EW'(d2[i] >>> ES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = $signed({pr_q[2*i][PW-1], pr_q[2*i]})
           - $signed({pr_q[2*i+1][PW-1], pr_q[2*i+1]});
      c_o[i] = c[i];
    end
    // zero cross product: flat or collapsed triangle
    deg_o = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
  end

endmodule

// ===== src/tfn_queue.sv =====
// Short queue between front and back end, flip-flop storage.
// Depends on tfn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tfn_queue import tfn_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]   mem_q [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] count_q;

  assign full_o  = (count_q == CNTW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PTRW'(1);
      if (pop_i)  rd_q <= rd_q + PTRW'(1);
      if (push_i && !pop_i)      count_q <= count_q + CNTW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `TFN_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> (!full_o || pop_i))
  `TFN_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)
  `TFN_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNTW'(QUEUE_DEPTH))
  `TFN_ASSERT_NEXT(a_count_grow, clk_i, rst_ni, push_i && !pop_i,
                   count_q == $past(count_q) + CNTW'(1))

endmodule

// ===== src/tfn_back.sv =====
// Back end: magnitude normalize, squares, pipelined square root and
// pipelined restoring divides, output register. Depends on tfn_pkg.
module tfn_back import tfn_pkg::*; #(
  parameter int CW   = cross_width(16),
  parameter int FRAC = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0][CW-1:0]   c_i,
  input  logic                 deg_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_WIDTH-1:0] normal_x_o,
  output logic [OUT_WIDTH-1:0] normal_y_o,
  output logic [OUT_WIDTH-1:0] normal_z_o,
  output logic                 degenerate_o
);

  localparam int AW   = CW - 1;
  localparam int TW   = $clog2(AW);
  localparam int NB   = NORM_BITS;
  localparam int DS   = FRAC + 1;
  localparam int NW   = NB + FRAC + 1;
  localparam int LAT  = 5 + SQRT_STEPS + DS;
  localparam int OW   = (FRAC + 2 > OUT_WIDTH) ? FRAC + 2 : OUT_WIDTH;

  logic en;
  logic [LAT-1:0] vld_q;
  logic out_valid_q;

  // stage B1..B4
  logic [AW-1:0] a1_q [3];
  logic [AW-1:0] or1_q;
  side_t         sd1_q, sd2_q, sd3_q, sd4_q;
  logic [AW-1:0] a2_q [3];
  logic [TW-1:0] top_q, top_d;
  logic [NB-1:0] an3_q [3];
  logic [NB-1:0] an4_q [3];
  logic [2*NB-1:0] sq4_q [3];
  logic [AW-1:0] a_mag [3];
  logic [TW:0]   shamt;

  // square root pipeline, index 0 is the sum stage
  logic [63:0]     s_q  [SQRT_STEPS+1];
  logic [63:0]     r_q  [SQRT_STEPS+1];
  logic [NB-1:0]   ans_q [SQRT_STEPS+1][3];
  side_t           sds_q [SQRT_STEPS+1];
  logic [63:0]     s_nx [SQRT_STEPS];
  logic [63:0]     r_nx [SQRT_STEPS];

  // divide pipeline
  logic [31:0]     nrm_q [DS];
  logic [NW-1:0]   rem_q [DS][3];
  logic [DS-1:0]   quo_q [DS][3];
  side_t           sdd_q [DS];
  logic [NW-1:0]   rem_nx [DS][3];
  logic [DS-1:0]   quo_nx [DS][3];
  logic [31:0]     nrm_src [DS];
  logic [NW-1:0]   rem_src [DS][3];
  logic [DS-1:0]   quo_src [DS][3];

  logic [OW-1:0]        res [3];
  logic [OUT_WIDTH-1:0] nx_q, ny_q, nz_q;
  logic                 deg_q;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign degenerate_o = deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], pop_o};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = c_i[i][CW-1] ? AW'(-$signed(c_i[i])) : c_i[i][AW-1:0];
    end
    // leading one of the OR word is the leading one of the largest magnitude
    top_d = '0;
    for (int b = 0; b < AW; b++) begin
      if (or1_q[b]) top_d = TW'(b);
    end
    shamt = (TW+1)'(top_q) + (TW+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i]  <= a_mag[i];
        a2_q[i]  <= a1_q[i];
        an3_q[i] <= NB'({a2_q[i], {NB{1'b0}}} >> shamt);
        an4_q[i] <= an3_q[i];
        sq4_q[i] <= an3_q[i] * an3_q[i];
      end
      or1_q <= a_mag[0] | a_mag[1] | a_mag[2];
      sd1_q <= '{neg: {c_i[2][CW-1], c_i[1][CW-1], c_i[0][CW-1]}, deg: deg_i};
      top_q <= top_d;
      sd2_q <= sd1_q;
      sd3_q <= sd2_q;
      sd4_q <= sd3_q;
    end
  end

  // one result bit per stage
  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (s_q[k] >= r_q[k] + (64'd1 << (62 - 2 * k))) begin
        s_nx[k] = s_q[k] - (r_q[k] + (64'd1 << (62 - 2 * k)));
        r_nx[k] = (r_q[k] >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        s_nx[k] = s_q[k];
        r_nx[k] = r_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0]   <= 64'(sq4_q[0]) + 64'(sq4_q[1]) + 64'(sq4_q[2]);
      r_q[0]   <= '0;
      ans_q[0] <= an4_q;
      sds_q[0] <= sd4_q;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        s_q[k+1]   <= s_nx[k];
        r_q[k+1]   <= r_nx[k];
        ans_q[k+1] <= ans_q[k];
        sds_q[k+1] <= sds_q[k];
      end
    end
  end

  // restoring divide, quotient bit FRAC-j in stage j
  always_comb begin
    for (int j = 0; j < DS; j++) begin
      if (j == 0) begin
        nrm_src[j] = r_q[SQRT_STEPS][31:0];
        for (int i = 0; i < 3; i++) begin
          rem_src[j][i] = {1'b0, ans_q[SQRT_STEPS][i], {FRAC{1'b0}}}
                        + NW'(r_q[SQRT_STEPS][31:1]);
          quo_src[j][i] = '0;
        end
      end else begin
        nrm_src[j] = nrm_q[j-1];
        for (int i = 0; i < 3; i++) begin
          rem_src[j][i] = rem_q[j-1][i];
          quo_src[j][i] = quo_q[j-1][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        quo_nx[j][i] = quo_src[j][i];
        if (rem_src[j][i] >= (NW'(nrm_src[j]) << (FRAC - j))) begin
          rem_nx[j][i] = rem_src[j][i] - (NW'(nrm_src[j]) << (FRAC - j));
          quo_nx[j][i][FRAC-j] = 1'b1;
        end else begin
          rem_nx[j][i] = rem_src[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DS; j++) begin
        nrm_q[j] <= nrm_src[j];
        rem_q[j] <= rem_nx[j];
        quo_q[j] <= quo_nx[j];
        sdd_q[j] <= (j == 0) ? sds_q[SQRT_STEPS] : sdd_q[j-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = (quo_q[DS-1][i] > (DS'(1) << FRAC)) ? (OW'(1) << FRAC)
                                                    : OW'(quo_q[DS-1][i]);
      if (sdd_q[DS-1].neg[i]) res[i] = -res[i];
      if (sdd_q[DS-1].deg)    res[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= res[0][OUT_WIDTH-1:0];
      ny_q  <= res[1][OUT_WIDTH-1:0];
      nz_q  <= res[2][OUT_WIDTH-1:0];
      deg_q <= sdd_q[DS-1].deg;
    end
  end

endmodule

// ===== src/triangle_face_normal.sv =====
// Top level of the triangle face normal engine.
// Depends on tfn_pkg, tfn_front, tfn_queue, tfn_back.
//
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o | p1_*_i, p2_*_i, p3_*_i
//  out     | out_valid_o / out_ready_i | normal_*_o, degenerate_o
//
// One triangle per cycle when the output is taken every cycle.
// Path: front register stages, queue, back end normalize, square and sum
// stages, a stage per square root bit and per quotient bit, output register.
// Reset clears valid flags, queue pointers and queue count only.
// The back pipeline stalls as a whole while the output waits; the queue
// absorbs the front until it fills, then in_ready_o drops.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] p1_x_i,
  input  logic [COORD_WIDTH-1:0] p1_y_i,
  input  logic [COORD_WIDTH-1:0] p1_z_i,
  input  logic [COORD_WIDTH-1:0] p2_x_i,
  input  logic [COORD_WIDTH-1:0] p2_y_i,
  input  logic [COORD_WIDTH-1:0] p2_z_i,
  input  logic [COORD_WIDTH-1:0] p3_x_i,
  input  logic [COORD_WIDTH-1:0] p3_y_i,
  input  logic [COORD_WIDTH-1:0] p3_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_WIDTH-1:0]   normal_x_o,
  output logic [OUT_WIDTH-1:0]   normal_y_o,
  output logic [OUT_WIDTH-1:0]   normal_z_o,
  output logic                   degenerate_o
);

  localparam int CW = cross_width(COORD_WIDTH);
  localparam int DW = 3 * CW + 1;

  logic              push, pop, full, empty, deg_f, deg_b;
  logic [2:0][CW-1:0] c_f, c_b;

  tfn_front #(.COORD_WIDTH(COORD_WIDTH), .CW(CW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .p1_x_i, .p1_y_i, .p1_z_i, .p2_x_i, .p2_y_i, .p2_z_i,
    .p3_x_i, .p3_y_i, .p3_z_i,
    .full_i(full), .push_o(push), .c_o(c_f), .deg_o(deg_f)
  );

  tfn_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i({deg_f, c_f}),
    .pop_i(pop), .data_o({deg_b, c_b}),
    .full_o(full), .empty_o(empty)
  );

  tfn_back #(.CW(CW), .FRAC(NORMAL_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .c_i(c_b), .deg_i(deg_b), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

endmodule
